// ----- src/assert_macros.svh -----
// Assertion helpers included by the RTL files that check themselves.
// Each macro samples on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled clock edge.
`define CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/brd_pkg.sv -----
// ----------------------------------------------------------------------------
// brd_pkg
// Request modes, result status codes and the decision struct of the deque.
// ----------------------------------------------------------------------------
`default_nettype none

package brd_pkg;

    localparam int unsigned DATA_W = 64;

    typedef enum logic [1:0] {
        MODE_PUSH_LEFT  = 2'd0,
        MODE_PUSH_RIGHT = 2'd1,
        MODE_POP_LEFT   = 2'd2,
        MODE_POP_RIGHT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Outcome of one request, from the pointer logic to the result stage
    typedef struct packed {
        logic    wr_en;
        logic    rd_en;
        status_t status;
        logic    now_empty;
    } decision_t;

endpackage

`default_nettype wire

// ----- src/bounded_ring_deque.sv -----
// ----------------------------------------------------------------------------
// bounded_ring_deque
// Double-ended queue of 64-bit words in a power-of-two ring, one result per
// request.
//
//   channel  | direction | fields                          | handshake
//   ---------+-----------+---------------------------------+----------------
//   s_       | in        | s_mode, s_data_in               | s_valid/s_ready
//   m_       | out       | m_status, m_data_out, m_now_empty | m_valid/m_ready
//
// One request per cycle unless the result stalls; each result appears in the
// cycle after its transfer. The pointer update and the single ring access
// happen in the transfer cycle; the ring read port registers the popped word straight into the result stage.
// A new request is taken whenever the result register is empty or drained in
// the same cycle; a stalled result stalls the input.
// Reset (aresetn low, synchronous) empties the deque; the ring is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bounded_ring_deque #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_mode,
    input  wire logic [brd_pkg::DATA_W-1:0] s_data_in,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic      [1:0]                 m_status,
    output logic      [brd_pkg::DATA_W-1:0] m_data_out,
    output logic                            m_now_empty
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                       s_fire;
    logic [AW-1:0]              slot_addr;
    brd_pkg::decision_t         dec;
    logic [brd_pkg::DATA_W-1:0] rd_data;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    brd_pkg::status_t           status_reg;
    logic                       now_empty_reg;
    logic                       rd_ok_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    brd_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_fire  (s_fire),
        .req_mode  (s_mode),
        .slot_addr (slot_addr),
        .dec       (dec)
    );

    brd_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (dec.wr_en),
        .rd_en   (dec.rd_en),
        .addr    (slot_addr),
        .wr_data (s_data_in),
        .rd_data (rd_data)
    );

    assign m_valid_next = s_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result fields load on each input transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            status_reg    <= dec.status;
            now_empty_reg <= dec.now_empty;
            rd_ok_reg     <= dec.rd_en;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_data_out  = rd_ok_reg ? rd_data : '0;
    assign m_now_empty = now_empty_reg;

    `CHECK_ALWAYS(a_refused_zero_data,
        !m_valid || (m_status == brd_pkg::ST_OK) || (m_data_out == '0),
        "refused request returned nonzero data")
    `CHECK_ALWAYS(a_empty_pop_flags,
        !m_valid || (m_status != brd_pkg::ST_EMPTY) || m_now_empty,
        "empty pop did not report an empty deque")
    `CHECK_ALWAYS(a_full_push_flags,
        !m_valid || (m_status != brd_pkg::ST_FULL) || !m_now_empty,
        "full push reported an empty deque")
    `CHECK_NEXT(a_fire_gives_result, s_valid && s_ready, m_valid,
        "transfer did not produce a result")

endmodule

`default_nettype wire

// ----- src/brd_ram.sv -----
// ----------------------------------------------------------------------------
// brd_ram
// Ring store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brd_ram #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               wr_en,
    input  wire logic                               rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           addr,
    input  wire logic [brd_pkg::DATA_W-1:0]         wr_data,
    output logic      [brd_pkg::DATA_W-1:0]         rd_data
);

    logic [brd_pkg::DATA_W-1:0] mem [DEPTH];
    logic [brd_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // Hold the last popped word until the next pop
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/brd_ctrl.sv -----
// ----------------------------------------------------------------------------
// brd_ctrl
// End pointers and fill count; decides each request and picks the ring slot.
// ----------------------------------------------------------------------------
`default_nettype none

module brd_ctrl #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         req_fire,
    input  wire logic [1:0]                   req_mode,
    output logic      [$clog2(DEPTH)-1:0]     slot_addr,
    output brd_pkg::decision_t                dec
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CNT_W = AW + 1;

    logic [AW-1:0]    left_reg,  left_next;
    logic [AW-1:0]    right_reg, right_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic is_full;
    logic is_empty;

    assign is_full  = (count_reg == CNT_W'(DEPTH - 1));
    assign is_empty = (count_reg == '0);

    always_comb begin
        left_next  = left_reg;
        right_next = right_reg;
        count_next = count_reg;
        slot_addr  = left_reg;
        dec        = '{wr_en: 1'b0, rd_en: 1'b0, status: brd_pkg::ST_OK, now_empty: 1'b0};

        unique case (brd_pkg::mode_t'(req_mode))
            brd_pkg::MODE_PUSH_LEFT: begin
                if (is_full) begin
                    dec.status = brd_pkg::ST_FULL;
                end else begin
                    dec.wr_en  = 1'b1;
                    slot_addr  = left_reg;
                    left_next  = left_reg + AW'(1);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            brd_pkg::MODE_PUSH_RIGHT: begin
                if (is_full) begin
                    dec.status = brd_pkg::ST_FULL;
                end else begin
                    dec.wr_en  = 1'b1;
                    right_next = right_reg - AW'(1);
                    slot_addr  = right_reg - AW'(1);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            brd_pkg::MODE_POP_LEFT: begin
                if (is_empty) begin
                    dec.status = brd_pkg::ST_EMPTY;
                end else begin
                    dec.rd_en  = 1'b1;
                    left_next  = left_reg - AW'(1);
                    slot_addr  = left_reg - AW'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            brd_pkg::MODE_POP_RIGHT: begin
                if (is_empty) begin
                    dec.status = brd_pkg::ST_EMPTY;
                end else begin
                    dec.rd_en  = 1'b1;
                    slot_addr  = right_reg;
                    right_next = right_reg + AW'(1);
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                dec.status = brd_pkg::ST_OK;
            end
        endcase

        dec.now_empty = (count_next == '0);

        // Drop the ring access and pointer updates unless the request transfers this cycle
        if (!req_fire) begin
            dec.wr_en  = 1'b0;
            dec.rd_en  = 1'b0;
            left_next  = left_reg;
            right_next = right_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            right_reg <= '0;
            count_reg <= '0;
        end else begin
            left_reg  <= left_next;
            right_reg <= right_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
